@@ hw/rtl/sgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgd_pkg
// Shared widths, codes and types of the scatter-gather descriptor builder.
// ============================================================================
package sgd_pkg;

    localparam int SEG_ADDR_W       = 32;
    localparam int SEG_BYTES_W      = 21;
    localparam int DESC_KIND_W      = 3;
    localparam int DESC_BYTES_W     = 16;
    localparam int DEF_MAX_COMMANDS = 256;
    localparam int DEF_CHUNK_BYTES  = 65024;
    localparam int RESULT_CAP       = 20;
    localparam int RC_W             = $clog2(RESULT_CAP + 1);

    localparam logic [SEG_BYTES_W-1:0] SEG_LIMIT = SEG_BYTES_W'(1048576);

    typedef enum logic [DESC_KIND_W-1:0] {
        KIND_IN_MORE  = 3'd0,
        KIND_OUT_MORE = 3'd1,
        KIND_IN_LAST  = 3'd2,
        KIND_OUT_LAST = 3'd3,
        KIND_STOP     = 3'd4,
        KIND_OVERFLOW = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_EVAL,
        OP_SPLIT,
        OP_LAST,
        OP_STOP,
        OP_FLUSH
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SPLIT,
        ST_LAST,
        ST_STOP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic ovf;
        logic len_zero;
        logic hit;
        logic p_valid;
        logic gt_chunk;
        logic count_full;
        logic final_seg;
        logic can_push;
    } t_sts;

endpackage
`default_nettype wire

@@ hw/rtl/sgd_seg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgd_seg_if
// Segment channel: one buffer segment per word.
// ============================================================================
interface sgd_seg_if;
    import sgd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SEG_ADDR_W-1:0]  seg_address;
    logic [SEG_BYTES_W-1:0] seg_bytes;
    logic                   final_segment;
    logic                   to_device;

    modport source (
        output valid, seg_address, seg_bytes, final_segment, to_device,
        input  ready
    );

    modport sink (
        input  valid, seg_address, seg_bytes, final_segment, to_device,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/sgd_desc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgd_desc_if
// Descriptor channel: one descriptor or status result per word.
// ============================================================================
interface sgd_desc_if;
    import sgd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [DESC_KIND_W-1:0]  desc_kind;
    logic [SEG_ADDR_W-1:0]   desc_address;
    logic [DESC_BYTES_W-1:0] desc_bytes;
    logic                    run_end;

    modport source (
        output valid, desc_kind, desc_address, desc_bytes, run_end,
        input  ready
    );

    modport sink (
        input  valid, desc_kind, desc_address, desc_bytes, run_end,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/sgd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgd_ctrl
// Sequencer: steps each segment through evaluate, split, last, stop, flush.
// ============================================================================
module sgd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_seg_valid,
    output logic               o_seg_ready,
    input  wire sgd_pkg::t_sts i_sts,
    output sgd_pkg::t_op       o_op
);
    import sgd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = OP_NONE;
        o_seg_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_seg_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.can_push) begin
                    o_op = OP_EVAL;
                    if (i_sts.ovf) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.len_zero) begin
                        n_state = i_sts.final_seg ? ST_LAST : ST_FLUSH;
                    end else if (!i_sts.hit && i_sts.p_valid && i_sts.count_full) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (i_sts.can_push) begin
                    o_op = OP_SPLIT;
                    if (i_sts.gt_chunk) begin
                        n_state = i_sts.count_full ? ST_FLUSH : ST_SPLIT;
                    end else begin
                        n_state = i_sts.final_seg ? ST_LAST : ST_FLUSH;
                    end
                end
            end
            ST_LAST: begin
                if (i_sts.can_push) begin
                    o_op    = OP_LAST;
                    n_state = (i_sts.p_valid && i_sts.count_full) ? ST_FLUSH : ST_STOP;
                end
            end
            ST_STOP: begin
                if (i_sts.can_push) begin
                    o_op    = OP_STOP;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.can_push) begin
                    o_op    = OP_FLUSH;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/sgd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgd_datapath
// Pending region, splitter, list counter, staging and output registers.
// ============================================================================
module sgd_datapath #(
    parameter int MAX_COMMANDS = sgd_pkg::DEF_MAX_COMMANDS,
    parameter int CHUNK_BYTES  = sgd_pkg::DEF_CHUNK_BYTES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sgd_pkg::t_op                    i_op,
    output sgd_pkg::t_sts                        o_sts,
    input  wire logic [sgd_pkg::SEG_ADDR_W-1:0]  i_seg_address,
    input  wire logic [sgd_pkg::SEG_BYTES_W-1:0] i_seg_bytes,
    input  wire logic                            i_final_segment,
    input  wire logic                            i_to_device,
    sgd_desc_if.source                           o_desc
);
    import sgd_pkg::*;

    localparam int CW = $clog2(MAX_COMMANDS);
    localparam logic [CW-1:0]           COUNT_TOP   = CW'(MAX_COMMANDS - 1);
    localparam logic [DESC_BYTES_W-1:0] CHUNK_16    = DESC_BYTES_W'(CHUNK_BYTES);
    localparam logic [SEG_BYTES_W-1:0]  CHUNK_W     = SEG_BYTES_W'(CHUNK_BYTES);
    localparam logic [SEG_ADDR_W-1:0]   CHUNK_A     = SEG_ADDR_W'(CHUNK_BYTES);

    // latched segment
    logic [SEG_ADDR_W-1:0]   r_s_addr,   n_s_addr;
    logic [SEG_BYTES_W-1:0]  r_s_len,    n_s_len;
    logic                    r_s_final,  n_s_final;
    logic                    r_s_dir,    n_s_dir;
    // region being split
    logic [SEG_ADDR_W-1:0]   r_w_addr,   n_w_addr;
    logic [SEG_BYTES_W-1:0]  r_w_total,  n_w_total;
    // list state
    logic [SEG_ADDR_W-1:0]   r_p_addr,   n_p_addr;
    logic [DESC_BYTES_W-1:0] r_p_bytes,  n_p_bytes;
    logic                    r_p_valid,  n_p_valid;
    logic [CW-1:0]           r_count,    n_count;
    logic                    r_ovf,      n_ovf;
    logic [RC_W-1:0]         r_rcount,   n_rcount;
    // staged result
    logic                    r_stg_v,    n_stg_v;
    t_kind                   r_stg_kind, n_stg_kind;
    logic [SEG_ADDR_W-1:0]   r_stg_addr, n_stg_addr;
    logic [DESC_BYTES_W-1:0] r_stg_bytes, n_stg_bytes;
    // output word
    logic                    r_out_v,    n_out_v;
    t_kind                   r_out_kind, n_out_kind;
    logic [SEG_ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [DESC_BYTES_W-1:0] r_out_bytes, n_out_bytes;
    logic                    r_out_end,  n_out_end;

    logic                    hit;
    logic                    count_full;
    logic                    can_push;
    t_kind                   more_kind;
    t_kind                   last_kind;

    logic                    d_req;
    t_kind                   d_kind;
    logic [SEG_ADDR_W-1:0]   d_addr;
    logic [DESC_BYTES_W-1:0] d_bytes;
    logic                    e_v;
    t_kind                   e_kind;
    logic [SEG_ADDR_W-1:0]   e_addr;
    logic [DESC_BYTES_W-1:0] e_bytes;
    logic                    fail;
    logic                    do_clear;

    assign hit        = r_p_valid &&
                        (r_s_addr == (r_p_addr + SEG_ADDR_W'(r_p_bytes)));
    assign count_full = (r_count >= COUNT_TOP);
    assign can_push   = !r_stg_v || !r_out_v || o_desc.ready;
    assign more_kind  = r_s_dir ? KIND_OUT_MORE : KIND_IN_MORE;
    assign last_kind  = r_s_dir ? KIND_OUT_LAST : KIND_IN_LAST;

    assign o_sts.ovf        = r_ovf;
    assign o_sts.len_zero   = (r_s_len == '0);
    assign o_sts.hit        = hit;
    assign o_sts.p_valid    = r_p_valid;
    assign o_sts.gt_chunk   = (r_w_total > CHUNK_W);
    assign o_sts.count_full = count_full;
    assign o_sts.final_seg  = r_s_final;
    assign o_sts.can_push   = can_push;

    assign o_desc.valid        = r_out_v;
    assign o_desc.desc_kind    = r_out_kind;
    assign o_desc.desc_address = r_out_addr;
    assign o_desc.desc_bytes   = r_out_bytes;
    assign o_desc.run_end      = r_out_end;

    always_comb begin
        n_s_addr    = r_s_addr;
        n_s_len     = r_s_len;
        n_s_final   = r_s_final;
        n_s_dir     = r_s_dir;
        n_w_addr    = r_w_addr;
        n_w_total   = r_w_total;
        n_p_addr    = r_p_addr;
        n_p_bytes   = r_p_bytes;
        n_p_valid   = r_p_valid;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rcount    = r_rcount;
        n_stg_v     = r_stg_v;
        n_stg_kind  = r_stg_kind;
        n_stg_addr  = r_stg_addr;
        n_stg_bytes = r_stg_bytes;
        n_out_v     = r_out_v && !o_desc.ready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_bytes = r_out_bytes;
        n_out_end   = r_out_end;
        d_req       = 1'b0;
        d_kind      = more_kind;
        d_addr      = r_p_addr;
        d_bytes     = r_p_bytes;
        e_v         = 1'b0;
        e_kind      = KIND_STOP;
        e_addr      = '0;
        e_bytes     = '0;
        fail        = 1'b0;
        do_clear    = 1'b0;

        case (i_op)
            OP_LOAD: begin
                n_s_addr  = i_seg_address;
                n_s_len   = (i_seg_bytes > SEG_LIMIT) ? SEG_LIMIT : i_seg_bytes;
                n_s_final = i_final_segment;
                n_s_dir   = i_to_device;
                n_rcount  = '0;
            end
            OP_EVAL: begin
                if (r_ovf) begin
                    do_clear = r_s_final;
                end else if (r_s_len != '0) begin
                    if (hit) begin
                        n_w_addr  = r_p_addr;
                        n_w_total = SEG_BYTES_W'(r_p_bytes) + r_s_len;
                    end else begin
                        d_req     = r_p_valid;
                        n_w_addr  = r_s_addr;
                        n_w_total = r_s_len;
                    end
                end
            end
            OP_SPLIT: begin
                if (r_w_total > CHUNK_W) begin
                    d_req     = 1'b1;
                    d_addr    = r_w_addr;
                    d_bytes   = CHUNK_16;
                    n_w_addr  = r_w_addr + CHUNK_A;
                    n_w_total = r_w_total - CHUNK_W;
                end else begin
                    n_p_addr  = r_w_addr;
                    n_p_bytes = r_w_total[DESC_BYTES_W-1:0];
                    n_p_valid = 1'b1;
                end
            end
            OP_LAST: begin
                d_req  = r_p_valid;
                d_kind = last_kind;
            end
            OP_STOP: begin
                e_v      = 1'b1;
                e_kind   = KIND_STOP;
                do_clear = 1'b1;
            end
            default: begin
            end
        endcase

        // data descriptor or overflow when the list is full
        if (d_req) begin
            e_v = 1'b1;
            if (count_full) begin
                fail      = 1'b1;
                e_kind    = KIND_OVERFLOW;
                n_ovf     = 1'b1;
                n_p_valid = 1'b0;
                n_p_addr  = '0;
                n_p_bytes = '0;
            end else begin
                n_count = r_count + CW'(1);
                e_kind  = d_kind;
                e_addr  = d_addr;
                e_bytes = d_bytes;
            end
        end

        if (fail && r_s_final) begin
            do_clear = 1'b1;
        end

        if (do_clear) begin
            n_p_addr  = '0;
            n_p_bytes = '0;
            n_p_valid = 1'b0;
            n_count   = '0;
            n_ovf     = 1'b0;
        end

        // staging: a word leaves for output once the next one is known
        if (e_v && (r_rcount < RC_W'(RESULT_CAP))) begin
            n_rcount = r_rcount + RC_W'(1);
            if (r_stg_v) begin
                n_out_v     = 1'b1;
                n_out_kind  = r_stg_kind;
                n_out_addr  = r_stg_addr;
                n_out_bytes = r_stg_bytes;
                n_out_end   = 1'b0;
            end
            n_stg_v     = 1'b1;
            n_stg_kind  = e_kind;
            n_stg_addr  = e_addr;
            n_stg_bytes = e_bytes;
        end

        if ((i_op == OP_FLUSH) && r_stg_v) begin
            n_out_v     = 1'b1;
            n_out_kind  = r_stg_kind;
            n_out_addr  = r_stg_addr;
            n_out_bytes = r_stg_bytes;
            n_out_end   = 1'b1;
            n_stg_v     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_addr  <= '0;
            r_p_bytes <= '0;
            r_p_valid <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_rcount  <= '0;
            r_stg_v   <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_p_addr  <= n_p_addr;
            r_p_bytes <= n_p_bytes;
            r_p_valid <= n_p_valid;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_rcount  <= n_rcount;
            r_stg_v   <= n_stg_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_addr    <= n_s_addr;
        r_s_len     <= n_s_len;
        r_s_final   <= n_s_final;
        r_s_dir     <= n_s_dir;
        r_w_addr    <= n_w_addr;
        r_w_total   <= n_w_total;
        r_stg_kind  <= n_stg_kind;
        r_stg_addr  <= n_stg_addr;
        r_stg_bytes <= n_stg_bytes;
        r_out_kind  <= n_out_kind;
        r_out_addr  <= n_out_addr;
        r_out_bytes <= n_out_bytes;
        r_out_end   <= n_out_end;
    end

    a_rcount_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcount <= RC_W'(RESULT_CAP))
        else $error("result count beyond cap");

    a_pending_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> ((r_p_bytes != '0) && (r_p_bytes <= CHUNK_16)))
        else $error("pending region size out of range");

    a_ovf_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> !r_p_valid)
        else $error("pending region kept after overflow");

    a_flush_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == OP_FLUSH) && r_stg_v) |=> (r_out_v && r_out_end && !r_stg_v))
        else $error("flush did not close the run");

endmodule
`default_nettype wire

@@ hw/rtl/sg_dma_descriptor_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sg_dma_descriptor_builder
// Builds a descriptor list from the buffer segments of one transfer.
//
//   channel   dir  word
//   i_seg     in   seg_address, seg_bytes, final_segment, to_device
//   o_desc    out  desc_kind, desc_address, desc_bytes, run_end
//
// One segment at a time. A segment with bytes goes through accept, evaluate,
// split and flush until its last word enters the output register, with one more
// split step per extra chunk; a final segment adds last and stop unless the
// list overflows. A zero-length segment skips the split; one dropped after
// an overflow ends after evaluate. The next segment is taken the cycle after.
// Each result is staged one word back, so that run_end is known when it leaves.
// A stalled o_desc holds the sequencer. Reset is synchronous, active low.
// ============================================================================
module sg_dma_descriptor_builder #(
    parameter int MAX_COMMANDS = sgd_pkg::DEF_MAX_COMMANDS,
    parameter int CHUNK_BYTES  = sgd_pkg::DEF_CHUNK_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sgd_seg_if.sink    i_seg,
    sgd_desc_if.source o_desc
);
    import sgd_pkg::*;

    t_op  op;
    t_sts sts;

    sgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg.valid),
        .o_seg_ready (i_seg.ready),
        .i_sts       (sts),
        .o_op        (op)
    );

    sgd_datapath #(
        .MAX_COMMANDS (MAX_COMMANDS),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_sts           (sts),
        .i_seg_address   (i_seg.seg_address),
        .i_seg_bytes     (i_seg.seg_bytes),
        .i_final_segment (i_seg.final_segment),
        .i_to_device     (i_seg.to_device),
        .o_desc          (o_desc)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> !i_seg.ready)
        else $error("segment accepted while one is in work");

endmodule
`default_nettype wire

@@ test/sg_dma_descriptor_builder_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sg_dma_descriptor_builder_tb
// Feeds segment lists into the descriptor builder and checks every descriptor
// word against typed expectations or a cycle-free model of the list builder.
// A short table of directed segments comes first: empty list, exact and
// one-over chunk sizes, address wrap, zero-length segments, flushes, clamping
// and list overflow. Random transfers follow, with bursty input, a patterned
// output stall, one long output hold and pauses that let the block drain.
// ============================================================================
module sg_dma_descriptor_builder_tb;
    import sgd_pkg::*;

    localparam int MAX_CMDS      = DEF_MAX_COMMANDS;
    localparam int CHUNK         = DEF_CHUNK_BYTES;
    localparam int RANDOM_SEGS   = 480;
    localparam int HOLD_AT       = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int MAX_PRINTED   = 40;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic [31:0] addr;
        logic [20:0] bytes;
        logic        fin;
        logic        dir;
    } t_seg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [15:0] bytes;
        logic        last;
    } t_desc;

    typedef struct {
        t_seg  seg;
        int    n_typed;
        t_desc want [3];
        bit    pause;
    } t_row;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOPPY
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    sgd_seg_if  seg_if();
    sgd_desc_if desc_if();

    sg_dma_descriptor_builder #(
        .MAX_COMMANDS(MAX_CMDS),
        .CHUNK_BYTES (CHUNK)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if),
        .o_desc (desc_if)
    );

    logic [31:0] run_addr;
    int unsigned run_bytes;
    bit          run_open;
    int          list_count;
    bit          list_full;

    t_desc step_out[$];
    t_desc desc_expected[$];
    t_row  stim_rows[$];

    int errors      = 0;
    int segs_sent   = 0;
    int transfers   = 0;
    int descs_seen  = 0;
    int stops_seen  = 0;
    int ovf_seen    = 0;
    bit hold_now    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d descriptors still outstanding", desc_expected.size());
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic void clear_list();
        run_addr   = '0;
        run_bytes  = 0;
        run_open   = 1'b0;
        list_count = 0;
        list_full  = 1'b0;
    endfunction

    function automatic void put_desc(t_kind k, logic [31:0] a, logic [15:0] b);
        t_desc d;
        if (step_out.size() >= RESULT_CAP)
            return;
        d.kind  = k;
        d.addr  = a;
        d.bytes = b;
        d.last  = 1'b0;
        step_out.push_back(d);
    endfunction

    function automatic bit emit_chunk(t_kind k, logic [31:0] a, int unsigned b);
        if (list_count + 1 >= MAX_CMDS) begin
            put_desc(KIND_OVERFLOW, '0, '0);
            list_full = 1'b1;
            run_open  = 1'b0;
            run_addr  = '0;
            run_bytes = 0;
            return 1'b0;
        end
        list_count++;
        put_desc(k, a, 16'(b));
        return 1'b1;
    endfunction

    function automatic void predict_segment(t_seg s);
        logic [31:0] a;
        int unsigned total;
        int unsigned len;
        bit          ok;
        t_kind       more_k;
        t_kind       last_k;
        t_desc       d;
        step_out.delete();
        ok     = 1'b1;
        more_k = s.dir ? KIND_OUT_MORE : KIND_IN_MORE;
        last_k = s.dir ? KIND_OUT_LAST : KIND_IN_LAST;
        if (list_full) begin
            if (s.fin)
                clear_list();
            return;
        end
        len = (s.bytes > SEG_LIMIT) ? SEG_LIMIT : s.bytes;
        if (len > 0) begin
            if (run_open && s.addr == 32'(run_addr + run_bytes)) begin
                a     = run_addr;
                total = run_bytes + len;
            end else begin
                if (run_open)
                    ok = emit_chunk(more_k, run_addr, run_bytes);
                a     = s.addr;
                total = len;
            end
            while (ok && total > CHUNK) begin
                ok    = emit_chunk(more_k, a, CHUNK);
                a     = a + CHUNK;
                total = total - CHUNK;
            end
            if (ok) begin
                run_addr  = a;
                run_bytes = total;
                run_open  = 1'b1;
            end
        end
        if (ok && s.fin) begin
            if (run_open)
                ok = emit_chunk(last_k, run_addr, run_bytes);
            if (ok)
                put_desc(KIND_STOP, '0, '0);
        end
        if (s.fin)
            clear_list();
        if (step_out.size() > 0) begin
            d = step_out.pop_back();
            d.last = 1'b1;
            step_out.push_back(d);
        end
    endfunction

    function automatic t_seg mk_seg(logic [31:0] a, logic [20:0] b, logic f, logic dr);
        t_seg s;
        s.addr  = a;
        s.bytes = b;
        s.fin   = f;
        s.dir   = dr;
        return s;
    endfunction

    function automatic t_desc dsc(t_kind k, logic [31:0] a, logic [15:0] b, logic l);
        t_desc d;
        d.kind  = k;
        d.addr  = a;
        d.bytes = b;
        d.last  = l;
        return d;
    endfunction

    function automatic void add_row(t_seg s, int n = -1, t_desc d0 = '0, t_desc d1 = '0,
                                    t_desc d2 = '0, bit pause = 1'b0);
        t_row r;
        r.seg     = s;
        r.n_typed = n;
        r.want[0] = d0;
        r.want[1] = d1;
        r.want[2] = d2;
        r.pause   = pause;
        stim_rows.push_back(r);
    endfunction

    function automatic void build_directed();
        // empty list right after reset
        add_row(mk_seg(32'h0, 21'd0, 1'b1, 1'b0), 1, dsc(KIND_STOP, '0, '0, 1'b1));
        // exactly one chunk
        add_row(mk_seg(32'hABCD_0000, 21'd65024, 1'b1, 1'b0), 2,
                dsc(KIND_IN_LAST, 32'hABCD_0000, 16'd65024, 1'b0),
                dsc(KIND_STOP, '0, '0, 1'b1));
        // one byte over a chunk
        add_row(mk_seg(32'h0, 21'd65025, 1'b1, 1'b1), 3,
                dsc(KIND_OUT_MORE, 32'h0, 16'd65024, 1'b0),
                dsc(KIND_OUT_LAST, 32'd65024, 16'd1, 1'b0),
                dsc(KIND_STOP, '0, '0, 1'b1));
        // merge across the top of the address space
        add_row(mk_seg(32'hFFFF_FF00, 21'd256, 1'b0, 1'b1), 0);
        add_row(mk_seg(32'h0, 21'd256, 1'b1, 1'b1), 2,
                dsc(KIND_OUT_LAST, 32'hFFFF_FF00, 16'd512, 1'b0),
                dsc(KIND_STOP, '0, '0, 1'b1));
        // zero-length segment between two that merge
        add_row(mk_seg(32'h100, 21'd100, 1'b0, 1'b0), 0);
        add_row(mk_seg(32'h5555, 21'd0, 1'b0, 1'b1), 0);
        add_row(mk_seg(32'h164, 21'd4, 1'b1, 1'b0), 2,
                dsc(KIND_IN_LAST, 32'h100, 16'd104, 1'b0),
                dsc(KIND_STOP, '0, '0, 1'b1));
        // gap flushes the pending region with the new direction
        add_row(mk_seg(32'h2000, 21'd16, 1'b0, 1'b0), 0);
        add_row(mk_seg(32'h8000, 21'd16, 1'b1, 1'b1), 3,
                dsc(KIND_OUT_MORE, 32'h2000, 16'd16, 1'b0),
                dsc(KIND_OUT_LAST, 32'h8000, 16'd16, 1'b0),
                dsc(KIND_STOP, '0, '0, 1'b1));
        // overlong segment is clamped
        add_row(mk_seg(32'h8000_0000, 21'h1F_FFFF, 1'b1, 1'b0));
        // list fills up on the sixteenth full-size segment
        for (int k = 1; k <= 16; k++)
            add_row(mk_seg(32'(k) << 24, SEG_LIMIT, 1'b0, 1'(k % 2)));
        add_row(mk_seg(32'h1234_5678, 21'd64, 1'b0, 1'b1), 0);
        add_row(mk_seg(32'h0, 21'd0, 1'b1, 1'b0), 0);
        add_row(mk_seg(32'h0, 21'd0, 1'b1, 1'b1), 1, dsc(KIND_STOP, '0, '0, 1'b1));
    endfunction

    function automatic logic [20:0] rand_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return 21'($urandom_range(1, 4096));
        else if (r < 85)
            return 21'($urandom_range(4097, 140000));
        else if (r < 93)
            return 21'($urandom_range(140001, 400000));
        else if (r < 97)
            return 21'($urandom_range(400001, 1048576));
        return 21'($urandom_range(1048577, 2097151));
    endfunction

    function automatic void add_random_rows();
        int          pick;
        int          nseg;
        int          count;
        bit          big;
        bit          noise;
        bit          paused_mid;
        logic [31:0] next_addr;
        t_seg        s;
        count      = 0;
        paused_mid = 1'b0;
        while (count < RANDOM_SEGS) begin
            pick      = $urandom_range(0, 99);
            big       = (pick < 4);
            noise     = (pick >= 4 && pick < 12);
            nseg      = big ? 21 : (noise ? $urandom_range(1, 3) : $urandom_range(1, 8));
            next_addr = $urandom();
            for (int i = 0; i < nseg; i++) begin
                s.addr = ($urandom_range(0, 99) < (big ? 30 : 60)) ? next_addr : $urandom();
                if (big)
                    s.bytes = 21'($urandom_range(900000, 2097151));
                else if (noise)
                    s.bytes = ($urandom_range(0, 1) != 0) ? '0 : rand_bytes();
                else
                    s.bytes = rand_bytes();
                s.fin = (i == nseg - 1);
                s.dir = 1'($urandom_range(0, 1));
                next_addr = s.addr + ((s.bytes > SEG_LIMIT) ? SEG_LIMIT : s.bytes);
                add_row(s, -1, '0, '0, '0,
                        (count == 0) || (!paused_mid && count >= RANDOM_SEGS / 2));
                if (count >= RANDOM_SEGS / 2)
                    paused_mid = 1'b1;
                count++;
            end
        end
    endfunction

    function automatic void accept_row(t_row r);
        predict_segment(r.seg);
        if (r.seg.fin)
            transfers++;
        if (r.n_typed < 0) begin
            foreach (step_out[i])
                desc_expected.push_back(step_out[i]);
        end else begin
            for (int i = 0; i < r.n_typed; i++)
                desc_expected.push_back(r.want[i]);
        end
    endfunction

    task automatic drive_segments();
        int   burst_left;
        int   gap;
        bit   lowered;
        t_row r;
        burst_left = $urandom_range(1, 12);
        lowered    = 1'b0;
        foreach (stim_rows[idx]) begin
            r = stim_rows[idx];
            if (r.pause && desc_expected.size() != 0) begin
                if (!lowered)
                    seg_if.valid <= 1'b0;
                while (desc_expected.size() != 0)
                    @(posedge i_clk);
            end
            seg_if.valid         <= 1'b1;
            seg_if.seg_address   <= r.seg.addr;
            seg_if.seg_bytes     <= r.seg.bytes;
            seg_if.final_segment <= r.seg.fin;
            seg_if.to_device     <= r.seg.dir;
            lowered = 1'b0;
            @(posedge i_clk);
            while (seg_if.ready !== 1'b1)
                @(posedge i_clk);
            accept_row(r);
            segs_sent++;
            if (segs_sent == HOLD_AT)
                hold_now = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    seg_if.valid <= 1'b0;
                    lowered = 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        if (!lowered)
            seg_if.valid <= 1'b0;
    endtask

    // output side stall pattern, with one long hold
    initial begin
        t_rx_mode mode;
        int       left;
        int       phase;
        desc_if.ready <= 1'b0;
        mode  = RX_OPEN;
        left  = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_now) begin
                hold_now = 1'b0;
                desc_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 100);
            end
            left--;
            phase++;
            case (mode)
                RX_OPEN:   desc_if.ready <= 1'b1;
                RX_COIN:   desc_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: desc_if.ready <= (phase % 4 == 0);
                default:   desc_if.ready <= (phase % 11) < 8;
            endcase
        end
    end

    // descriptor word checker
    always @(posedge i_clk) begin
        t_desc w;
        if (i_rst_n === 1'b1 && desc_if.valid === 1'b1 && desc_if.ready === 1'b1) begin
            descs_seen++;
            if (desc_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d addr %h bytes %0d end %b",
                                          desc_if.desc_kind, desc_if.desc_address,
                                          desc_if.desc_bytes, desc_if.run_end));
            end else begin
                w = desc_expected.pop_front();
                if (desc_if.desc_kind !== w.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              desc_if.desc_kind, w.kind));
                if (desc_if.desc_address !== w.addr)
                    report_mismatch($sformatf("address %h, wanted %h",
                                              desc_if.desc_address, w.addr));
                if (desc_if.desc_bytes !== w.bytes)
                    report_mismatch($sformatf("bytes %0d, wanted %0d",
                                              desc_if.desc_bytes, w.bytes));
                if (desc_if.run_end !== w.last)
                    report_mismatch($sformatf("run_end %b, wanted %b",
                                              desc_if.run_end, w.last));
                if (w.kind == KIND_STOP)
                    stops_seen++;
                if (w.kind == KIND_OVERFLOW)
                    ovf_seen++;
            end
        end
    end

    initial begin
        int drain;
        i_rst_n              <= 1'b0;
        seg_if.valid         <= 1'b0;
        seg_if.seg_address   <= '0;
        seg_if.seg_bytes     <= '0;
        seg_if.final_segment <= 1'b0;
        seg_if.to_device     <= 1'b0;
        clear_list();
        build_directed();
        add_random_rows();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_segments();
        drain = 0;
        while (desc_expected.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (desc_expected.size() != 0)
            report_mismatch($sformatf("%0d descriptors never arrived", desc_expected.size()));
        $display("%0d segments in %0d transfers, %0d descriptor words checked",
                 segs_sent, transfers, descs_seen);
        $display("%0d stop words, %0d list overflows, one %0d-cycle output hold, %0d errors",
                 stops_seen, ovf_seen, HOLD_CYCLES, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_seg_if.sv
hw/rtl/sgd_desc_if.sv
hw/rtl/sgd_ctrl.sv
hw/rtl/sgd_datapath.sv
hw/rtl/sg_dma_descriptor_builder.sv
test/sg_dma_descriptor_builder_tb.sv
